@@ design/lrse_pkg.sv @@
`default_nettype none

package lrse_pkg;

   localparam int DEF_NUM_STATES   = 256;
   localparam int DEF_NUM_SYMBOLS  = 256;
   localparam int DEF_NUM_RULES    = 256;
   localparam int DEF_MAX_RULE_LEN = 15;
   localparam int DEF_STACK_DEPTH  = 64;
   localparam int DEF_MAX_REDUCES  = 63;

   localparam int OP_W    = 2;
   localparam int FIELD_W = 8;
   localparam int CODE_W  = 3;
   localparam int LEN_W   = 4;
   localparam int KIND_W  = 2;
   localparam int LEVEL_W = 7;
   localparam int CMP_W   = 11;
   localparam int ENTRY_W = CODE_W + FIELD_W;
   localparam int RULE_W  = LEN_W + FIELD_W;

   localparam logic [OP_W-1:0] OP_ACTION = 2'd0;
   localparam logic [OP_W-1:0] OP_RULE   = 2'd1;
   localparam logic [OP_W-1:0] OP_TOKEN  = 2'd2;

   localparam logic [CODE_W-1:0] CODE_ERROR  = 3'd0;
   localparam logic [CODE_W-1:0] CODE_SHIFT  = 3'd1;
   localparam logic [CODE_W-1:0] CODE_REDUCE = 3'd2;
   localparam logic [CODE_W-1:0] CODE_GOTO   = 3'd3;
   localparam logic [CODE_W-1:0] CODE_ACCEPT = 3'd4;

   localparam logic [KIND_W-1:0] EV_SHIFT  = 2'd0;
   localparam logic [KIND_W-1:0] EV_REDUCE = 2'd1;
   localparam logic [KIND_W-1:0] EV_ACCEPT = 2'd2;
   localparam logic [KIND_W-1:0] EV_ERROR  = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [FIELD_W-1:0] rule;
      logic [FIELD_W-1:0] state;
      logic [LEVEL_W-1:0] level;
      logic               last;
   } event_type;

   localparam event_type EVENT_ERROR  = '{EV_ERROR, '0, '0, LEVEL_W'(1), 1'b1};
   localparam event_type EVENT_ACCEPT = '{EV_ACCEPT, '0, '0, LEVEL_W'(1), 1'b1};

endpackage

`default_nettype wire

@@ design/lrse_ram.sv @@
`default_nettype none

module lrse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/lr_shift_reduce_engine.sv @@
// LR shift/reduce parse engine.
// Input channel (req_*): one transaction per item. Operation action-write
// loads {entry_code, entry_target} at (row_state, symbol); rule-write loads
// {rule_length, rule_lhs} at rule_number; token runs the parser on symbol.
// Loads are written in the cycle they are accepted and produce no result.
// Result channel (rsp_*): one transaction per event. A token gives zero or
// more reduce events followed by one shift, accept or error with rsp_last set.
// Sequence: a reduce runs through the chain action read, rule read, stack
// read, goto read, result load; the reads each go through a synchronous
// memory. A shift, accept or error decided at the action read goes straight
// to the result load.
// Reset: the stack returns to a single state 0 entry, and the action memory
// is swept to the error code, one entry per cycle, 2^(row bits + symbol bits)
// entries (65536 at the default sizes) with req_ready low. Rule entries are
// undefined until written.
// Stall: a result waits in the output register while rsp_ready is low; the
// engine holds at its next event until that register frees.
`default_nettype none

module lr_shift_reduce_engine
   import lrse_pkg::*;
#(
   parameter int NUM_STATES   = DEF_NUM_STATES,
   parameter int NUM_SYMBOLS  = DEF_NUM_SYMBOLS,
   parameter int NUM_RULES    = DEF_NUM_RULES,
   parameter int MAX_RULE_LEN = DEF_MAX_RULE_LEN,
   parameter int STACK_DEPTH  = DEF_STACK_DEPTH,
   parameter int MAX_REDUCES  = DEF_MAX_REDUCES
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [OP_W-1:0]    req_operation,
   input  wire logic [FIELD_W-1:0] req_row_state,
   input  wire logic [FIELD_W-1:0] req_symbol,
   input  wire logic [CODE_W-1:0]  req_entry_code,
   input  wire logic [FIELD_W-1:0] req_entry_target,
   input  wire logic [FIELD_W-1:0] req_rule_number,
   input  wire logic [FIELD_W-1:0] req_rule_lhs,
   input  wire logic [LEN_W-1:0]   req_rule_length,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic      [KIND_W-1:0]  rsp_event_kind,
   output logic      [FIELD_W-1:0] rsp_event_rule,
   output logic      [FIELD_W-1:0] rsp_event_state,
   output logic      [LEVEL_W-1:0] rsp_stack_level,
   output logic                    rsp_last
);

   localparam int ROW_W   = (NUM_STATES > 256) ? FIELD_W : $clog2(NUM_STATES);
   localparam int SYM_W   = $clog2(NUM_SYMBOLS);
   localparam int ACT_AW  = ROW_W + SYM_W;
   localparam int ACT_DEPTH = 2 ** ACT_AW;
   localparam int RULE_AW = (NUM_RULES > 256) ? FIELD_W :
                            (NUM_RULES < 2) ? 1 : $clog2(NUM_RULES);
   localparam int RULE_DEPTH = 2 ** RULE_AW;
   localparam int STK_AW  = $clog2(STACK_DEPTH);
   localparam int SP_W    = $clog2(STACK_DEPTH + 1);
   localparam int RED_W   = $clog2(MAX_REDUCES + 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_ACT,
      S_RULE,
      S_STK,
      S_GOTO,
      S_EMIT
   } state_type;

   state_type          state_ff;
   logic [ACT_AW-1:0]  clr_cnt_ff;
   logic [FIELD_W-1:0] sym_ff;
   logic [FIELD_W-1:0] top_ff;
   logic [FIELD_W-1:0] lhs_ff;
   logic [FIELD_W-1:0] rule_ff;
   logic [SP_W-1:0]    sp_ff;
   logic [SP_W-1:0]    spn_ff;
   logic [RED_W-1:0]   red_cnt_ff;
   logic               go_ok_ff;
   event_type          ev_ff;
   event_type          rsp_ff;
   logic               rsp_valid_ff;

   logic               accept;
   logic               out_free;
   logic               emit_go;
   logic               top_ok;
   logic               sym_ok;
   logic               t_ok;
   logic               lhs_ok;
   logic [CODE_W-1:0]  a_code;
   logic [FIELD_W-1:0] a_target;
   logic [CODE_W-1:0]  g_code;
   logic [FIELD_W-1:0] g_state;
   logic [LEN_W-1:0]   rule_len;
   logic [FIELD_W-1:0] rule_lhs;
   logic [SP_W-1:0]    sp_inc;
   logic [SP_W-1:0]    spn_inc;
   logic [SP_W-1:0]    sp_minus;
   logic [SP_W-1:0]    sp_below;
   logic [FIELD_W-1:0] stk_t;
   logic               shift_go;
   logic               goto_go;

   logic               act_we;
   logic [ACT_AW-1:0]  act_waddr;
   logic [ENTRY_W-1:0] act_wdata;
   logic [ACT_AW-1:0]  act_raddr;
   logic [ENTRY_W-1:0] act_rdata;
   logic               rule_we;
   logic [RULE_AW-1:0] rule_waddr;
   logic [RULE_AW-1:0] rule_raddr;
   logic [RULE_W-1:0]  rule_rdata;
   logic               stk_we;
   logic [STK_AW-1:0]  stk_waddr;
   logic [FIELD_W-1:0] stk_wdata;
   logic [STK_AW-1:0]  stk_raddr;
   logic [FIELD_W-1:0] stk_rdata;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit_go   = (state_ff == S_EMIT) && out_free;

   assign top_ok   = CMP_W'(top_ff) < CMP_W'(NUM_STATES);
   assign sym_ok   = CMP_W'(sym_ff) < CMP_W'(NUM_SYMBOLS);
   assign a_code   = (top_ok && sym_ok) ? act_rdata[ENTRY_W-1:FIELD_W] : CODE_ERROR;
   assign a_target = act_rdata[FIELD_W-1:0];
   assign g_code   = go_ok_ff ? act_rdata[ENTRY_W-1:FIELD_W] : CODE_ERROR;
   assign g_state  = act_rdata[FIELD_W-1:0];
   assign rule_len = rule_rdata[RULE_W-1:FIELD_W];
   assign rule_lhs = rule_rdata[FIELD_W-1:0];
   assign sp_inc   = sp_ff + SP_W'(1);
   assign spn_inc  = spn_ff + SP_W'(1);
   assign sp_minus = sp_ff - SP_W'(rule_len);
   assign sp_below = sp_minus - SP_W'(1);
   assign stk_t    = (spn_ff == SP_W'(1)) ? '0 : stk_rdata;
   assign t_ok     = CMP_W'(stk_t) < CMP_W'(NUM_STATES);
   assign lhs_ok   = CMP_W'(lhs_ff) < CMP_W'(NUM_SYMBOLS);

   assign shift_go = (state_ff == S_ACT) && (a_code == CODE_SHIFT) &&
                     (CMP_W'(sp_ff) < CMP_W'(STACK_DEPTH));
   assign goto_go  = (state_ff == S_GOTO) && (g_code == CODE_GOTO) &&
                     (CMP_W'(spn_ff) < CMP_W'(STACK_DEPTH));

   always_comb begin
      act_we    = 1'b0;
      act_waddr = {req_row_state[ROW_W-1:0], req_symbol[SYM_W-1:0]};
      act_wdata = {req_entry_code, req_entry_target};
      act_raddr = {top_ff[ROW_W-1:0], sym_ff[SYM_W-1:0]};
      unique case (state_ff)
         S_CLEAR: begin
            act_we    = 1'b1;
            act_waddr = clr_cnt_ff;
            act_wdata = {CODE_ERROR, FIELD_W'(0)};
         end
         S_IDLE: begin
            act_we    = accept && (req_operation == OP_ACTION) &&
                        (CMP_W'(req_row_state) < CMP_W'(NUM_STATES)) &&
                        (CMP_W'(req_symbol) < CMP_W'(NUM_SYMBOLS));
            act_raddr = {top_ff[ROW_W-1:0], req_symbol[SYM_W-1:0]};
         end
         S_STK: begin
            act_raddr = {stk_t[ROW_W-1:0], lhs_ff[SYM_W-1:0]};
         end
         default: begin
         end
      endcase
   end

   assign rule_we    = accept && (req_operation == OP_RULE) &&
                       (CMP_W'(req_rule_number) < CMP_W'(NUM_RULES));
   assign rule_waddr = req_rule_number[RULE_AW-1:0];
   assign rule_raddr = a_target[RULE_AW-1:0];

   assign stk_we    = shift_go || goto_go;
   assign stk_waddr = goto_go ? spn_ff[STK_AW-1:0] : sp_ff[STK_AW-1:0];
   assign stk_wdata = goto_go ? g_state : a_target;
   assign stk_raddr = sp_below[STK_AW-1:0];

   lrse_ram #(.WIDTH(ENTRY_W), .DEPTH(ACT_DEPTH)) u_action_ram (
      .clock   (clock),
      .wr_en   (act_we),
      .wr_addr (act_waddr),
      .wr_data (act_wdata),
      .rd_addr (act_raddr),
      .rd_data (act_rdata)
   );

   lrse_ram #(.WIDTH(RULE_W), .DEPTH(RULE_DEPTH)) u_rule_ram (
      .clock   (clock),
      .wr_en   (rule_we),
      .wr_addr (rule_waddr),
      .wr_data ({req_rule_length, req_rule_lhs}),
      .rd_addr (rule_raddr),
      .rd_data (rule_rdata)
   );

   lrse_ram #(.WIDTH(FIELD_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         sp_ff        <= SP_W'(1);
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= emit_go || (rsp_valid_ff && !rsp_ready);
         unique case (state_ff)
            S_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + ACT_AW'(1);
               if (clr_cnt_ff == '1) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (accept && (req_operation == OP_TOKEN)) begin
                  sym_ff     <= req_symbol;
                  red_cnt_ff <= '0;
                  state_ff   <= S_ACT;
               end
            end
            S_ACT: begin
               unique case (a_code)
                  CODE_SHIFT: begin
                     if (shift_go) begin
                        sp_ff  <= sp_inc;
                        top_ff <= a_target;
                        ev_ff  <= '{EV_SHIFT, '0, a_target, LEVEL_W'(sp_inc), 1'b1};
                     end else begin
                        sp_ff  <= SP_W'(1);
                        top_ff <= '0;
                        ev_ff  <= EVENT_ERROR;
                     end
                     state_ff <= S_EMIT;
                  end
                  CODE_REDUCE: begin
                     if ((CMP_W'(red_cnt_ff) >= CMP_W'(MAX_REDUCES)) ||
                         (CMP_W'(a_target) >= CMP_W'(NUM_RULES))) begin
                        sp_ff    <= SP_W'(1);
                        top_ff   <= '0;
                        ev_ff    <= EVENT_ERROR;
                        state_ff <= S_EMIT;
                     end else begin
                        rule_ff  <= a_target;
                        state_ff <= S_RULE;
                     end
                  end
                  CODE_ACCEPT: begin
                     sp_ff    <= SP_W'(1);
                     top_ff   <= '0;
                     ev_ff    <= EVENT_ACCEPT;
                     state_ff <= S_EMIT;
                  end
                  default: begin
                     sp_ff    <= SP_W'(1);
                     top_ff   <= '0;
                     ev_ff    <= EVENT_ERROR;
                     state_ff <= S_EMIT;
                  end
               endcase
            end
            S_RULE: begin
               if ((CMP_W'(rule_len) > CMP_W'(MAX_RULE_LEN)) ||
                   (CMP_W'(rule_len) >= CMP_W'(sp_ff))) begin
                  sp_ff    <= SP_W'(1);
                  top_ff   <= '0;
                  ev_ff    <= EVENT_ERROR;
                  state_ff <= S_EMIT;
               end else begin
                  spn_ff   <= sp_minus;
                  lhs_ff   <= rule_lhs;
                  state_ff <= S_STK;
               end
            end
            S_STK: begin
               go_ok_ff <= t_ok && lhs_ok;
               state_ff <= S_GOTO;
            end
            S_GOTO: begin
               if (goto_go) begin
                  sp_ff      <= spn_inc;
                  top_ff     <= g_state;
                  red_cnt_ff <= red_cnt_ff + RED_W'(1);
                  ev_ff      <= '{EV_REDUCE, rule_ff, g_state, LEVEL_W'(spn_inc), 1'b0};
               end else begin
                  sp_ff  <= SP_W'(1);
                  top_ff <= '0;
                  ev_ff  <= EVENT_ERROR;
               end
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_ff   <= ev_ff;
                  state_ff <= ev_ff.last ? S_IDLE : S_ACT;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_kind  = rsp_ff.kind;
   assign rsp_event_rule  = rsp_ff.rule;
   assign rsp_event_state = rsp_ff.state;
   assign rsp_stack_level = rsp_ff.level;
   assign rsp_last        = rsp_ff.last;

endmodule

`default_nettype wire

@@ design/lrse_checker.sv @@
`default_nettype none

module lrse_port_checker
   import lrse_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [KIND_W-1:0]  rsp_event_kind,
   input wire logic [FIELD_W-1:0] rsp_event_rule,
   input wire logic [FIELD_W-1:0] rsp_event_state,
   input wire logic [LEVEL_W-1:0] rsp_stack_level,
   input wire logic               rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_kind) &&
      $stable(rsp_event_rule) && $stable(rsp_event_state) &&
      $stable(rsp_stack_level) && $stable(rsp_last))
      else $error("result transaction changed while stalled");

   a_final_reset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_event_kind == EV_ERROR) || (rsp_event_kind == EV_ACCEPT)) |->
      rsp_last && (rsp_stack_level == LEVEL_W'(1)) &&
      (rsp_event_rule == '0) && (rsp_event_state == '0))
      else $error("accept or error without stack reset");

   a_shift_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_kind == EV_SHIFT) |-> rsp_last && (rsp_event_rule == '0))
      else $error("shift is not the final event");

   a_reduce_more: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_kind == EV_REDUCE) |-> !rsp_last)
      else $error("reduce marked as final event");

   a_reset_sweep: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("engine open right after reset");

endmodule

bind lr_shift_reduce_engine lrse_port_checker u_lrse_port_checker (.*);

`default_nettype wire

@@ tb/lrse_checker.sv @@
module lrse_checker
   import lrse_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [OP_W-1:0]    req_operation,
   input  logic [FIELD_W-1:0] req_row_state,
   input  logic [FIELD_W-1:0] req_symbol,
   input  logic [CODE_W-1:0]  req_entry_code,
   input  logic [FIELD_W-1:0] req_entry_target,
   input  logic [FIELD_W-1:0] req_rule_number,
   input  logic [FIELD_W-1:0] req_rule_lhs,
   input  logic [LEN_W-1:0]   req_rule_length,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [KIND_W-1:0]  rsp_event_kind,
   input  logic [FIELD_W-1:0] rsp_event_rule,
   input  logic [FIELD_W-1:0] rsp_event_state,
   input  logic [LEVEL_W-1:0] rsp_stack_level,
   input  logic               rsp_last,
   output int                 mismatches,
   output int                 pending
);

   localparam int REPORT_LIMIT = 10;

   logic [ENTRY_W-1:0] action_mem [DEF_NUM_STATES*DEF_NUM_SYMBOLS];
   logic [RULE_W-1:0]  rule_mem   [DEF_NUM_RULES];
   logic [FIELD_W-1:0] stack_mem  [DEF_STACK_DEPTH];
   int                 depth;
   event_type          expected_events [$];

   function automatic logic [ENTRY_W-1:0] entry_at(input int st, input int sym);
      if (st >= DEF_NUM_STATES || sym >= DEF_NUM_SYMBOLS) return '0;
      return action_mem[st*DEF_NUM_SYMBOLS + sym];
   endfunction

   function automatic string describe(input event_type ev);
      return $sformatf("kind %0d rule %0d state %0d level %0d last %0d",
                       ev.kind, ev.rule, ev.state, ev.level, ev.last);
   endfunction

   task automatic flag(input string text);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("%0t: %s", $realtime, text);
   endtask

   task automatic queue_event(input logic [KIND_W-1:0] kind, input logic [FIELD_W-1:0] rule_id,
                              input logic [FIELD_W-1:0] st, input int level, input logic last);
      event_type ev;
      ev.kind  = kind;
      ev.rule  = rule_id;
      ev.state = st;
      ev.level = LEVEL_W'(level);
      ev.last  = last;
      expected_events.push_back(ev);
   endtask

   task automatic clear_tables;
      int i;
      for (i = 0; i < DEF_NUM_STATES*DEF_NUM_SYMBOLS; i++) action_mem[i] = '0;
      for (i = 0; i < DEF_NUM_RULES; i++) rule_mem[i] = '0;
      stack_mem[0] = '0;
      depth = 1;
      expected_events.delete();
      mismatches = 0;
   endtask

   task automatic parse_token(input logic [FIELD_W-1:0] sym);
      logic [ENTRY_W-1:0] act;
      logic [ENTRY_W-1:0] go;
      logic [CODE_W-1:0]  code;
      logic [FIELD_W-1:0] target;
      logic [FIELD_W-1:0] lhs;
      int                 len;
      int                 base;
      int                 reduces;
      bit                 done;
      bit                 fail;
      reduces = 0;
      done = 1'b0;
      while (!done) begin
         act = entry_at(int'(stack_mem[depth-1]), int'(sym));
         code = act[ENTRY_W-1:FIELD_W];
         target = act[FIELD_W-1:0];
         fail = 1'b1;
         done = 1'b1;
         if (code == CODE_SHIFT && depth < DEF_STACK_DEPTH) begin
            stack_mem[depth] = target;
            depth++;
            queue_event(EV_SHIFT, '0, target, depth, 1'b1);
            fail = 1'b0;
         end else if (code == CODE_ACCEPT) begin
            stack_mem[0] = '0;
            depth = 1;
            queue_event(EV_ACCEPT, '0, '0, 1, 1'b1);
            fail = 1'b0;
         end else if (code == CODE_REDUCE && reduces < DEF_MAX_REDUCES &&
                      target < DEF_NUM_RULES) begin
            lhs = rule_mem[target][FIELD_W-1:0];
            len = int'(rule_mem[target][RULE_W-1:FIELD_W]);
            base = depth - len;
            if (len <= DEF_MAX_RULE_LEN && len < depth && base < DEF_STACK_DEPTH) begin
               go = entry_at(int'(stack_mem[base-1]), int'(lhs));
               if (go[ENTRY_W-1:FIELD_W] == CODE_GOTO) begin
                  stack_mem[base] = go[FIELD_W-1:0];
                  depth = base + 1;
                  reduces++;
                  queue_event(EV_REDUCE, target, go[FIELD_W-1:0], depth, 1'b0);
                  fail = 1'b0;
                  done = 1'b0;
               end
            end
         end
         if (fail) begin
            stack_mem[0] = '0;
            depth = 1;
            queue_event(EV_ERROR, '0, '0, 1, 1'b1);
         end
      end
   endtask

   task automatic apply_request;
      case (req_operation)
         OP_ACTION: begin
            if (req_row_state < DEF_NUM_STATES && req_symbol < DEF_NUM_SYMBOLS)
               action_mem[int'(req_row_state)*DEF_NUM_SYMBOLS + int'(req_symbol)] =
                  {req_entry_code, req_entry_target};
         end
         OP_RULE: begin
            if (req_rule_number < DEF_NUM_RULES)
               rule_mem[req_rule_number] = {req_rule_length, req_rule_lhs};
         end
         OP_TOKEN: parse_token(req_symbol);
         default: ;
      endcase
   endtask

   task automatic check_event;
      event_type got;
      event_type want;
      got.kind  = rsp_event_kind;
      got.rule  = rsp_event_rule;
      got.state = rsp_event_state;
      got.level = rsp_stack_level;
      got.last  = rsp_last;
      if (expected_events.size() == 0) begin
         flag($sformatf("unexpected event: %s", describe(got)));
      end else begin
         want = expected_events.pop_front();
         if (got.kind !== want.kind || got.rule !== want.rule || got.state !== want.state ||
             got.level !== want.level || got.last !== want.last)
            flag($sformatf("event mismatch: expected %s, got %s", describe(want), describe(got)));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_tables();
      end else begin
         if (req_valid && req_ready) apply_request();
         if (rsp_valid && rsp_ready) check_event();
      end
      pending = expected_events.size();
   end

endmodule

@@ tb/tb_top.sv @@
module tb_top;
   import lrse_pkg::*;

   localparam logic [OP_W-1:0]   OP_NONE         = 2'd3;
   localparam logic [CODE_W-1:0] CODE_SPARE_LOW  = 3'd5;
   localparam logic [CODE_W-1:0] CODE_SPARE_HIGH = 3'd7;
   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 7;
   localparam int RUN_LIMIT    = 2000000;
   localparam int DRAIN_CYCLES = 1000;
   localparam int MIX_ITEMS    = 17;

   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic               req_valid        = 1'b0;
   logic               req_ready;
   logic [OP_W-1:0]    req_operation    = '0;
   logic [FIELD_W-1:0] req_row_state    = '0;
   logic [FIELD_W-1:0] req_symbol       = '0;
   logic [CODE_W-1:0]  req_entry_code   = '0;
   logic [FIELD_W-1:0] req_entry_target = '0;
   logic [FIELD_W-1:0] req_rule_number  = '0;
   logic [FIELD_W-1:0] req_rule_lhs     = '0;
   logic [LEN_W-1:0]   req_rule_length  = '0;
   logic               rsp_valid;
   logic               rsp_ready        = 1'b0;
   logic [KIND_W-1:0]  rsp_event_kind;
   logic [FIELD_W-1:0] rsp_event_rule;
   logic [FIELD_W-1:0] rsp_event_state;
   logic [LEVEL_W-1:0] rsp_stack_level;
   logic               rsp_last;

   int send_idle = 19;
   int recv_idle = 71;
   int mismatches;
   int pending;
   int cycle_count;
   bit rule_ok [DEF_NUM_RULES];

   logic [FIELD_W-1:0] state_pool   [6];
   logic [FIELD_W-1:0] term_pool    [4];
   logic [FIELD_W-1:0] nonterm_pool [2];
   logic [FIELD_W-1:0] rule_pool    [3];

   lr_shift_reduce_engine u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_row_state    (req_row_state),
      .req_symbol       (req_symbol),
      .req_entry_code   (req_entry_code),
      .req_entry_target (req_entry_target),
      .req_rule_number  (req_rule_number),
      .req_rule_lhs     (req_rule_lhs),
      .req_rule_length  (req_rule_length),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_event_rule   (rsp_event_rule),
      .rsp_event_state  (rsp_event_state),
      .rsp_stack_level  (rsp_stack_level),
      .rsp_last         (rsp_last)
   );

   lrse_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_row_state    (req_row_state),
      .req_symbol       (req_symbol),
      .req_entry_code   (req_entry_code),
      .req_entry_target (req_entry_target),
      .req_rule_number  (req_rule_number),
      .req_rule_lhs     (req_rule_lhs),
      .req_rule_length  (req_rule_length),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_event_rule   (rsp_event_rule),
      .rsp_event_state  (rsp_event_state),
      .rsp_stack_level  (rsp_stack_level),
      .rsp_last         (rsp_last),
      .mismatches       (mismatches),
      .pending          (pending)
   );

   always #(HALF_PERIOD) clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   task automatic send_item(input logic [OP_W-1:0] op, input logic [FIELD_W-1:0] row,
                            input logic [FIELD_W-1:0] sym, input logic [CODE_W-1:0] code,
                            input logic [FIELD_W-1:0] target, input logic [FIELD_W-1:0] num,
                            input logic [FIELD_W-1:0] lhs, input logic [LEN_W-1:0] len);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_row_state    <= row;
      req_symbol       <= sym;
      req_entry_code   <= code;
      req_entry_target <= target;
      req_rule_number  <= num;
      req_rule_lhs     <= lhs;
      req_rule_length  <= len;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_action(input logic [FIELD_W-1:0] row, input logic [FIELD_W-1:0] sym,
                              input logic [CODE_W-1:0] code, input logic [FIELD_W-1:0] target);
      send_item(OP_ACTION, row, sym, code, target, FIELD_W'($urandom), FIELD_W'($urandom),
                LEN_W'($urandom));
   endtask

   task automatic send_rule(input logic [FIELD_W-1:0] num, input logic [FIELD_W-1:0] lhs,
                            input logic [LEN_W-1:0] len);
      rule_ok[num] = 1'b1;
      send_item(OP_RULE, FIELD_W'($urandom), FIELD_W'($urandom), CODE_W'($urandom),
                FIELD_W'($urandom), num, lhs, len);
   endtask

   task automatic send_token(input logic [FIELD_W-1:0] sym);
      send_item(OP_TOKEN, FIELD_W'($urandom), sym, CODE_W'($urandom), FIELD_W'($urandom),
                FIELD_W'($urandom), FIELD_W'($urandom), LEN_W'($urandom));
   endtask

   function automatic logic [LEN_W-1:0] pick_length();
      return ($urandom_range(9) == 0) ? LEN_W'(DEF_MAX_RULE_LEN) : LEN_W'($urandom_range(2));
   endfunction

   task automatic send_noise;
      logic [OP_W-1:0]    op;
      logic [FIELD_W-1:0] row;
      logic [FIELD_W-1:0] sym;
      logic [CODE_W-1:0]  code;
      logic [FIELD_W-1:0] target;
      logic [FIELD_W-1:0] num;
      logic [FIELD_W-1:0] lhs;
      logic [LEN_W-1:0]   len;
      op = OP_W'($urandom);
      row = FIELD_W'($urandom);
      sym = FIELD_W'($urandom);
      code = CODE_W'($urandom);
      target = FIELD_W'($urandom);
      num = FIELD_W'($urandom);
      lhs = FIELD_W'($urandom);
      len = LEN_W'($urandom);
      if (op == OP_ACTION && code == CODE_REDUCE && !rule_ok[target]) target = rule_pool[0];
      if (op == OP_RULE) rule_ok[num] = 1'b1;
      send_item(op, row, sym, code, target, num, lhs, len);
   endtask

   // chain of zero-length reduces then a shift back to state 0, repeated until the stack fills
   task automatic climb_stack(input int rungs);
      logic [FIELD_W-1:0] sym;
      logic [FIELD_W-1:0] nt;
      logic [FIELD_W-1:0] rule_id;
      logic [FIELD_W-1:0] base;
      int                 i;
      sym = FIELD_W'($urandom);
      nt = sym ^ 8'h80;
      rule_id = FIELD_W'($urandom);
      base = FIELD_W'($urandom_range(248, 1));
      send_rule(rule_id, nt, '0);
      send_action('0, sym, CODE_REDUCE, rule_id);
      send_action('0, nt, CODE_GOTO, base);
      for (i = 0; i < rungs - 1; i++) begin
         send_action(FIELD_W'(base + i), sym, CODE_REDUCE, rule_id);
         send_action(FIELD_W'(base + i), nt, CODE_GOTO, FIELD_W'(base + i + 1));
      end
      send_action(FIELD_W'(base + rungs - 1), sym, CODE_SHIFT, '0);
      repeat (DEF_STACK_DEPTH / (rungs + 1)) send_token(sym);
   endtask

   task automatic random_item;
      int                 pick;
      int                 sel;
      logic [CODE_W-1:0]  code;
      logic [FIELD_W-1:0] target;
      pick = $urandom_range(99);
      if (pick < 28) begin
         if ($urandom_range(2) == 0) begin
            code = ($urandom_range(7) == 0) ? CODE_ERROR : CODE_GOTO;
            send_action(state_pool[$urandom_range(5)], nonterm_pool[$urandom_range(1)], code,
                        state_pool[$urandom_range(5)]);
         end else begin
            sel = $urandom_range(19);
            if (sel < 8) code = CODE_SHIFT;
            else if (sel < 14) code = CODE_REDUCE;
            else if (sel < 16) code = CODE_ACCEPT;
            else code = CODE_W'($urandom);
            target = (code == CODE_REDUCE) ? rule_pool[$urandom_range(2)]
                                           : state_pool[$urandom_range(5)];
            send_action(state_pool[$urandom_range(5)], term_pool[$urandom_range(3)], code, target);
         end
      end else if (pick < 34) begin
         send_rule(rule_pool[$urandom_range(2)], nonterm_pool[$urandom_range(1)], pick_length());
      end else if (pick < 40) begin
         send_noise();
      end else if ($urandom_range(9) == 0) begin
         send_token(FIELD_W'($urandom));
      end else begin
         send_token(term_pool[$urandom_range(3)]);
      end
   endtask

   task automatic run_phase(input int sender_pct, input int receiver_pct);
      int i;
      send_idle = sender_pct;
      recv_idle = receiver_pct;
      state_pool[0] = '0;
      for (i = 1; i < 6; i++) state_pool[i] = FIELD_W'($urandom);
      for (i = 0; i < 4; i++) term_pool[i] = FIELD_W'($urandom);
      for (i = 0; i < 2; i++) nonterm_pool[i] = FIELD_W'($urandom);
      for (i = 0; i < 3; i++) rule_pool[i] = FIELD_W'($urandom);
      for (i = 0; i < 3; i++)
         send_rule(rule_pool[i], nonterm_pool[$urandom_range(1)], pick_length());
      climb_stack($urandom_range(1) ? 7 : 3);
      repeat (MIX_ITEMS) random_item();
   endtask

   initial begin
      cycle_count = 0;
      while (cycle_count < RUN_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** lr_shift_reduce_engine: FAILED **");
      $finish;
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      send_item(OP_NONE, '1, '1, '1, '1, '1, '1, '1);
      send_token(8'd0);
      send_action(8'd255, 8'd255, CODE_SPARE_HIGH, 8'd255);
      send_action(8'd0, 8'd255, CODE_SPARE_LOW, 8'd0);
      send_token(8'd255);
      send_action(8'd0, 8'd1, CODE_GOTO, 8'd3);
      send_token(8'd1);
      send_rule(8'd255, 8'd255, 4'd15);
      send_rule(8'd0, 8'd254, 4'd0);
      send_rule(8'd1, 8'd253, 4'd1);
      send_action(8'd0, 8'd2, CODE_SHIFT, 8'd200);
      send_token(8'd2);
      send_action(8'd200, 8'd3, CODE_REDUCE, 8'd255);
      send_token(8'd3);
      send_action(8'd0, 8'd4, CODE_REDUCE, 8'd0);
      send_token(8'd4);
      send_action(8'd0, 8'd5, CODE_REDUCE, 8'd0);
      send_action(8'd0, 8'd254, CODE_GOTO, 8'd0);
      send_token(8'd5);
      send_token(8'd2);
      send_action(8'd200, 8'd5, CODE_REDUCE, 8'd0);
      send_action(8'd200, 8'd254, CODE_GOTO, 8'd0);
      send_token(8'd5);
      send_action(8'd0, 8'd6, CODE_SHIFT, 8'd9);
      send_action(8'd9, 8'd7, CODE_REDUCE, 8'd1);
      send_action(8'd0, 8'd253, CODE_GOTO, 8'd10);
      send_action(8'd10, 8'd7, CODE_ACCEPT, 8'd0);
      send_token(8'd6);
      send_token(8'd7);

      run_phase(19, 71);
      run_phase(71, 19);
      run_phase(0, 0);

      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("** lr_shift_reduce_engine: PASSED **");
      end else begin
         $display("** lr_shift_reduce_engine: FAILED **");
      end
      $finish;
   end

endmodule
